### hdl/hca_pkg.sv
// shared types, constants and codes of the heap chunk allocator
package hca_pkg;

	localparam int HEAP_BYTES   = 4096;
	localparam int HEADER_BYTES = 8;
	localparam int STORE_DEPTH  = HEAP_BYTES / 4;
	localparam int ADDR_W       = $clog2(STORE_DEPTH);
	localparam int OFF_W        = $clog2(HEAP_BYTES);
	localparam int SIZE_W       = 12;
	localparam int PREV_W       = ADDR_W + 1;
	localparam int HSZ_W        = 13;
	localparam int EXT_W        = 14;
	localparam int HDR_W        = SIZE_W + 1;
	localparam int MIN_HEAP     = 16;
	localparam int CNT_W        = ADDR_W + 1;

	localparam logic OP_ALLOC  = 1'b0;
	localparam logic OP_FREE   = 1'b1;
	localparam logic REG_BASE  = 1'b0;
	localparam logic REG_SIZE  = 1'b1;
	localparam logic ST_OK     = 1'b0;
	localparam logic ST_NOFIT  = 1'b1;

	typedef struct packed {
		logic        opcode;
		logic [12:0] request_bytes;
		logic [31:0] block_address;
	} in_item_t;

	typedef struct packed {
		logic        status;
		logic [31:0] data_address;
	} out_item_t;

	typedef struct packed {
		logic              is_free;
		logic [SIZE_W-1:0] size;
	} hdr_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		hdr_t              wdata;
		logic [ADDR_W-1:0] raddr;
	} hdr_req_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [PREV_W-1:0] wdata;
		logic [ADDR_W-1:0] raddr;
	} prev_req_t;

	typedef struct packed {
		logic             init;
		logic [HSZ_W-1:0] init_size;
		logic [31:0]      base;
		logic [HSZ_W-1:0] heap_len;
	} cfg_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_A_WALK,
		S_A_WR1,
		S_A_WR2,
		S_F_RD1,
		S_F_RD2,
		S_F_RD3,
		S_DONE
	} state_t;

endpackage

### hdl/heap_chunk_allocator_top.sv
// top level: register port, header stores and allocator sequencer
// allocate: walks the chunks from the head, one header read a cycle (at most 1024 chunks),
//   then writes the chosen header, plus a second write when a split leaves a free remainder
// free: three header reads, one merge write; rejected addresses go straight to done
// results are shown for one cycle on done; the receiver cannot stall
// reset clears all 1024 header store entries with busy high, then the heap is one free chunk
module heap_chunk_allocator_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  hca_pkg::in_item_t  item,
	output logic               done,
	output hca_pkg::out_item_t result,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	logic [29:0]               base_q;
	logic [hca_pkg::HSZ_W-1:0] hsize_q;
	logic                      wr_en;
	logic [hca_pkg::HSZ_W-1:0] hsize_raw;
	logic [hca_pkg::HSZ_W-1:0] hsize_new;
	hca_pkg::cfg_t             cfg;
	hca_pkg::hdr_req_t         hdr_req;
	hca_pkg::prev_req_t        prev_req;
	logic [hca_pkg::HDR_W-1:0] hdr_rdata;
	logic [hca_pkg::PREV_W-1:0] prev_rdata;

	// register transfer decode and size clamp
	assign pready    = 1'b1;
	assign wr_en     = psel && penable && pwrite;
	assign hsize_raw = pwdata[hca_pkg::HSZ_W-1:0] & ~hca_pkg::HSZ_W'(3);
	always_comb begin
		if (hsize_raw < hca_pkg::HSZ_W'(hca_pkg::MIN_HEAP)) begin
			hsize_new = hca_pkg::HSZ_W'(hca_pkg::MIN_HEAP);
		end else if (hsize_raw > hca_pkg::HSZ_W'(hca_pkg::HEAP_BYTES)) begin
			hsize_new = hca_pkg::HSZ_W'(hca_pkg::HEAP_BYTES);
		end else begin
			hsize_new = hsize_raw;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q  <= '0;
			hsize_q <= hca_pkg::HSZ_W'(hca_pkg::HEAP_BYTES);
		end else if (wr_en) begin
			if (paddr[2] == hca_pkg::REG_BASE) begin
				base_q <= pwdata[31:2];
			end else begin
				hsize_q <= hsize_new;
			end
		end
	end

	assign prdata = (paddr[2] == hca_pkg::REG_SIZE) ? {19'd0, hsize_q} : {base_q, 2'b00};

	assign cfg.init      = wr_en;
	assign cfg.init_size = (wr_en && paddr[2] == hca_pkg::REG_SIZE) ? hsize_new : hsize_q;
	assign cfg.base      = {base_q, 2'b00};
	assign cfg.heap_len  = hsize_q;

	// header stores
	hca_ram #(.WIDTH(hca_pkg::HDR_W), .DEPTH(hca_pkg::STORE_DEPTH)) u_hdr_ram (
		.clk   (clk),
		.we    (hdr_req.we),
		.waddr (hdr_req.waddr),
		.wdata (hdr_req.wdata),
		.raddr (hdr_req.raddr),
		.rdata (hdr_rdata)
	);

	hca_ram #(.WIDTH(hca_pkg::PREV_W), .DEPTH(hca_pkg::STORE_DEPTH)) u_prev_ram (
		.clk   (clk),
		.we    (prev_req.we),
		.waddr (prev_req.waddr),
		.wdata (prev_req.wdata),
		.raddr (prev_req.raddr),
		.rdata (prev_rdata)
	);

	// sequencer
	hca_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.item       (item),
		.cfg        (cfg),
		.busy       (busy),
		.done       (done),
		.result     (result),
		.hdr_req    (hdr_req),
		.hdr_rdata  (hca_pkg::hdr_t'(hdr_rdata)),
		.prev_req   (prev_req),
		.prev_rdata (prev_rdata)
	);

`ifndef SYNTHESIS
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted transfer did not raise busy");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy)
		else $error("sequencer not idle after result");
	a_nofit_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status == hca_pkg::ST_NOFIT) |-> (result.data_address == 32'd0))
		else $error("failed allocation carries an address");
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy || start))
		else $error("result without work");
`endif

endmodule

### hdl/hca_ram.sv
// generic single write port ram with registered read
module hca_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### hdl/hca_seq.sv
// sequencer for chunk walk, split, merge and reset clearing pass
module hca_seq (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  hca_pkg::in_item_t     item,
	input  hca_pkg::cfg_t         cfg,
	output logic                  busy,
	output logic                  done,
	output hca_pkg::out_item_t    result,
	output hca_pkg::hdr_req_t     hdr_req,
	input  hca_pkg::hdr_t         hdr_rdata,
	output hca_pkg::prev_req_t    prev_req,
	input  logic [hca_pkg::PREV_W-1:0] prev_rdata
);

	localparam logic [hca_pkg::EXT_W-1:0] HDR_EXT = hca_pkg::EXT_W'(hca_pkg::HEADER_BYTES);

	hca_pkg::state_t state_q, state_n;

	logic [hca_pkg::ADDR_W-1:0] clr_q;
	logic [hca_pkg::OFF_W-1:0]  off_q;
	logic [hca_pkg::CNT_W-1:0]  steps_q;
	logic [hca_pkg::EXT_W-1:0]  need_q;
	logic [hca_pkg::OFF_W-1:0]  best_off_q;
	logic [hca_pkg::SIZE_W-1:0] best_size_q;
	logic                       best_pow_q;
	logic                       found_q;
	logic                       exact_q;
	logic [hca_pkg::OFF_W-1:0]  c_q;
	logic [hca_pkg::SIZE_W-1:0] size_c_q;
	logic [hca_pkg::OFF_W-1:0]  p_q;
	logic                       p_ok_q;
	logic [hca_pkg::OFF_W-1:0]  begin_q;
	logic [hca_pkg::OFF_W-1:0]  nxt_q;
	logic                       nxt_in_q;
	hca_pkg::out_item_t         result_q;

	logic [hca_pkg::EXT_W-1:0]  heap_ext;
	logic [hca_pkg::EXT_W-1:0]  need_n;
	logic [31:0]                c32;
	logic                       c_ok;
	logic [hca_pkg::EXT_W-1:0]  s_ext;
	logic                       fit;
	logic                       exact_hit;
	logic [hca_pkg::EXT_W-1:0]  rem;
	logic [hca_pkg::EXT_W-1:0]  rem8;
	logic                       score;
	logic                       upd;
	logic [hca_pkg::CNT_W-1:0]  steps_n;
	logic [hca_pkg::EXT_W-1:0]  walk_nxt;
	logic                       walk_cont;
	logic [hca_pkg::EXT_W-1:0]  best_ext;
	logic [hca_pkg::EXT_W-1:0]  bsize_ext;
	logic                       split;
	logic [hca_pkg::EXT_W-1:0]  rem_off;
	logic [hca_pkg::EXT_W-1:0]  rem_sz;
	logic [hca_pkg::EXT_W-1:0]  after_best;
	logic [31:0]                alloc_addr;
	logic [hca_pkg::PREV_W-1:0] link_m1;
	logic [hca_pkg::OFF_W-1:0]  p_n;
	logic                       p_ok_n;
	logic [hca_pkg::OFF_W-1:0]  begin_n;
	logic [hca_pkg::EXT_W-1:0]  f_nxt;
	logic                       f_nxt_free;
	logic [hca_pkg::OFF_W-1:0]  end_off;
	logic [hca_pkg::SIZE_W-1:0] end_size;
	logic [hca_pkg::EXT_W-1:0]  merge_sum;
	logic [hca_pkg::SIZE_W-1:0] merge_sz;
	logic [hca_pkg::EXT_W-1:0]  f_nxt2;
	hca_pkg::hdr_t              head_hdr;

	// shared offset arithmetic
	assign heap_ext   = {1'b0, cfg.heap_len};
	assign need_n     = ({1'b0, item.request_bytes} + hca_pkg::EXT_W'(3)) & ~hca_pkg::EXT_W'(3);
	assign c32        = item.block_address - cfg.base - 32'(hca_pkg::HEADER_BYTES);
	assign c_ok       = (c32 < {19'd0, cfg.heap_len}) && (c32[1:0] == 2'b00);
	assign s_ext      = {2'b00, hdr_rdata.size};
	assign fit        = hdr_rdata.is_free && (s_ext >= need_q);
	assign exact_hit  = fit && (s_ext == need_q);
	assign rem        = s_ext - need_q;
	assign rem8       = rem - HDR_EXT;
	assign score      = (rem >= HDR_EXT) && ((rem8 & (rem8 - hca_pkg::EXT_W'(1))) == '0);
	assign upd        = fit && !(found_q && best_pow_q);
	assign steps_n    = steps_q + hca_pkg::CNT_W'(1);
	assign walk_nxt   = {2'b00, off_q} + s_ext + HDR_EXT;
	assign walk_cont  = !exact_hit && (walk_nxt < heap_ext)
		&& (steps_n < hca_pkg::CNT_W'(hca_pkg::STORE_DEPTH));
	assign best_ext   = {2'b00, best_off_q};
	assign bsize_ext  = {2'b00, best_size_q};
	assign split      = !exact_q && ((bsize_ext - need_q) >= HDR_EXT);
	assign rem_off    = best_ext + need_q + HDR_EXT;
	assign rem_sz     = bsize_ext - need_q - HDR_EXT;
	assign after_best = best_ext + bsize_ext + HDR_EXT;
	assign alloc_addr = cfg.base + {20'd0, best_off_q} + 32'(hca_pkg::HEADER_BYTES);
	assign link_m1    = prev_rdata - hca_pkg::PREV_W'(1);
	assign p_n        = {link_m1[hca_pkg::ADDR_W-1:0], 2'b00};
	assign p_ok_n     = (prev_rdata != '0) && (p_n < c_q);
	assign begin_n    = (p_ok_q && hdr_rdata.is_free) ? p_q : c_q;
	assign f_nxt      = {2'b00, c_q} + {2'b00, size_c_q} + HDR_EXT;
	assign f_nxt_free = nxt_in_q && hdr_rdata.is_free;
	assign end_off    = f_nxt_free ? nxt_q : c_q;
	assign end_size   = f_nxt_free ? hdr_rdata.size : size_c_q;
	assign merge_sum  = {2'b00, end_off} - {2'b00, begin_q} + {2'b00, end_size};
	assign merge_sz   = merge_sum[hca_pkg::SIZE_W-1:0];
	assign f_nxt2     = {2'b00, begin_q} + {2'b00, merge_sz} + HDR_EXT;
	assign head_hdr   = '{is_free: 1'b1,
		size: hca_pkg::SIZE_W'(cfg.init_size - hca_pkg::HSZ_W'(hca_pkg::HEADER_BYTES))};

	// next state and store requests
	always_comb begin
		state_n  = state_q;
		hdr_req  = '0;
		prev_req = '0;
		case (state_q)
			hca_pkg::S_CLEAR: begin
				if (!cfg.init) begin
					hdr_req.we    = 1'b1;
					hdr_req.waddr = clr_q;
					hdr_req.wdata = (clr_q == '0) ? head_hdr : '0;
					if (clr_q == '0) begin
						prev_req.we = 1'b1;
						state_n     = hca_pkg::S_IDLE;
					end
				end
			end
			hca_pkg::S_IDLE: begin
				if (start) begin
					if (item.opcode == hca_pkg::OP_ALLOC) begin
						hdr_req.raddr = '0;
						state_n       = hca_pkg::S_A_WALK;
					end else if (c_ok) begin
						hdr_req.raddr  = c32[hca_pkg::OFF_W-1:2];
						prev_req.raddr = c32[hca_pkg::OFF_W-1:2];
						state_n        = hca_pkg::S_F_RD1;
					end else begin
						state_n = hca_pkg::S_DONE;
					end
				end
			end
			hca_pkg::S_A_WALK: begin
				hdr_req.raddr = walk_nxt[hca_pkg::OFF_W-1:2];
				if (!walk_cont) begin
					state_n = hca_pkg::S_A_WR1;
				end
			end
			hca_pkg::S_A_WR1: begin
				state_n = hca_pkg::S_DONE;
				if (found_q) begin
					hdr_req.we            = 1'b1;
					hdr_req.waddr         = best_off_q[hca_pkg::OFF_W-1:2];
					hdr_req.wdata.is_free = 1'b0;
					hdr_req.wdata.size    = split ? need_q[hca_pkg::SIZE_W-1:0] : best_size_q;
					if (split && (rem_off < heap_ext)) begin
						prev_req.we    = 1'b1;
						prev_req.waddr = rem_off[hca_pkg::OFF_W-1:2];
						prev_req.wdata = {1'b0, best_off_q[hca_pkg::OFF_W-1:2]}
							+ hca_pkg::PREV_W'(1);
						state_n        = hca_pkg::S_A_WR2;
					end
				end
			end
			hca_pkg::S_A_WR2: begin
				hdr_req.we            = 1'b1;
				hdr_req.waddr         = rem_off[hca_pkg::OFF_W-1:2];
				hdr_req.wdata.is_free = 1'b1;
				hdr_req.wdata.size    = rem_sz[hca_pkg::SIZE_W-1:0];
				if (after_best < heap_ext) begin
					prev_req.we    = 1'b1;
					prev_req.waddr = after_best[hca_pkg::OFF_W-1:2];
					prev_req.wdata = {1'b0, rem_off[hca_pkg::OFF_W-1:2]} + hca_pkg::PREV_W'(1);
				end
				state_n = hca_pkg::S_DONE;
			end
			hca_pkg::S_F_RD1: begin
				hdr_req.raddr = p_n[hca_pkg::OFF_W-1:2];
				state_n       = hca_pkg::S_F_RD2;
			end
			hca_pkg::S_F_RD2: begin
				hdr_req.raddr = f_nxt[hca_pkg::OFF_W-1:2];
				state_n       = hca_pkg::S_F_RD3;
			end
			hca_pkg::S_F_RD3: begin
				hdr_req.we            = 1'b1;
				hdr_req.waddr         = begin_q[hca_pkg::OFF_W-1:2];
				hdr_req.wdata.is_free = 1'b1;
				hdr_req.wdata.size    = merge_sz;
				if (f_nxt2 < heap_ext) begin
					prev_req.we    = 1'b1;
					prev_req.waddr = f_nxt2[hca_pkg::OFF_W-1:2];
					prev_req.wdata = {1'b0, begin_q[hca_pkg::OFF_W-1:2]} + hca_pkg::PREV_W'(1);
				end
				state_n = hca_pkg::S_DONE;
			end
			hca_pkg::S_DONE: begin
				state_n = hca_pkg::S_IDLE;
			end
			default: begin
				state_n = hca_pkg::S_IDLE;
			end
		endcase
		// a register write rebuilds the head chunk
		if (cfg.init) begin
			hdr_req.we     = 1'b1;
			hdr_req.waddr  = '0;
			hdr_req.wdata  = head_hdr;
			prev_req.we    = 1'b1;
			prev_req.waddr = '0;
			prev_req.wdata = '0;
		end
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hca_pkg::S_CLEAR;
			clr_q   <= '1;
		end else begin
			state_q <= state_n;
			if (state_q == hca_pkg::S_CLEAR && !cfg.init) begin
				clr_q <= clr_q - hca_pkg::ADDR_W'(1);
			end
		end
	end

	// walk, merge and result registers
	always_ff @(posedge clk) begin
		case (state_q)
			hca_pkg::S_IDLE: begin
				off_q    <= '0;
				steps_q  <= '0;
				need_q   <= need_n;
				found_q  <= 1'b0;
				exact_q  <= 1'b0;
				best_pow_q <= 1'b0;
				c_q      <= c32[hca_pkg::OFF_W-1:0];
				result_q <= '{status: hca_pkg::ST_OK, data_address: 32'd0};
			end
			hca_pkg::S_A_WALK: begin
				steps_q <= steps_n;
				off_q   <= walk_nxt[hca_pkg::OFF_W-1:0];
				if (exact_hit || upd) begin
					best_off_q  <= off_q;
					best_size_q <= hdr_rdata.size;
					best_pow_q  <= score;
					found_q     <= 1'b1;
					exact_q     <= exact_hit;
				end
			end
			hca_pkg::S_A_WR1: begin
				if (found_q) begin
					result_q <= '{status: hca_pkg::ST_OK, data_address: alloc_addr};
				end else begin
					result_q <= '{status: hca_pkg::ST_NOFIT, data_address: 32'd0};
				end
			end
			hca_pkg::S_F_RD1: begin
				size_c_q <= hdr_rdata.size;
				p_q      <= p_n;
				p_ok_q   <= p_ok_n;
			end
			hca_pkg::S_F_RD2: begin
				begin_q  <= begin_n;
				nxt_q    <= f_nxt[hca_pkg::OFF_W-1:0];
				nxt_in_q <= f_nxt < heap_ext;
			end
			default: begin
			end
		endcase
	end

	assign busy   = (state_q != hca_pkg::S_IDLE);
	assign done   = (state_q == hca_pkg::S_DONE);
	assign result = result_q;

endmodule
